FILE: hw/rtl/gfdc_pkg.sv
// ----------------------------------------------------------------------------
// gfdc_pkg
// Shared types and constants of the gray frame difference counter.
// ----------------------------------------------------------------------------
`default_nettype none

package gfdc_pkg;

    localparam int NUM_REGIONS = 4;
    localparam int HW_REGIONS  = 4;
    localparam int MAX_PIXELS  = 4194304;

    localparam int PIX_W  = 8;
    localparam int MASK_W = 4;
    localparam int CNT_W  = 23;
    localparam int PCT_W  = 7;
    localparam int MODE_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] CNT_LIMIT =
        CNT_W'((MAX_PIXELS < CNT_MAX) ? MAX_PIXELS : CNT_MAX);

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    // numerator of the percent: changed * 100
    localparam int DIV_W = CNT_W + PCT_W;

    localparam int FIFO_DEPTH = 4;

    localparam logic [MODE_W-1:0] MODE_ALL     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MASK    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REGIONS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIX_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_CNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_THR_0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_THR_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_THR_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_THR_3 = 3'd6;

    typedef struct packed {
        logic [PIX_W-1:0]  old_pixel;
        logic [PIX_W-1:0]  new_pixel;
        logic [MASK_W-1:0] region_mask;
        logic              last;
    } t_pix;

    typedef struct packed {
        logic [PCT_W-1:0] percent;
        logic [CNT_W-1:0] region_count_0;
        logic [CNT_W-1:0] region_count_1;
        logic [CNT_W-1:0] region_count_2;
        logic [CNT_W-1:0] region_count_3;
    } t_res;

    // classified pixel, front to back
    typedef struct packed {
        logic                  inc_changed;
        logic [HW_REGIONS-1:0] inc_region;
        logic                  use_mask;
        logic                  regions_mode;
        logic                  last;
    } t_cls;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c < CNT_LIMIT) ? c + CNT_W'(1) : c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gfdc_front.sv
// ----------------------------------------------------------------------------
// gfdc_front
// Configuration registers and per-pixel classification against thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module gfdc_front
    import gfdc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_pix                  i_pix,
    input  wire logic                  i_full,
    output logic                       o_push,
    output t_cls                       o_entry,
    output logic [CNT_W-1:0]           o_mask_count
);

    logic [MODE_W-1:0] r_mode;
    logic [PIX_W-1:0]  r_pix_thr;
    logic [CNT_W-1:0]  r_mask_cnt;
    logic [PIX_W-1:0]  r_reg_thr [HW_REGIONS];

    logic [PIX_W-1:0] diff;
    logic             pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_ALL;
            r_pix_thr  <= '0;
            r_mask_cnt <= '0;
            for (int r = 0; r < HW_REGIONS; r++) begin
                r_reg_thr[r] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:      r_mode       <= i_cfg_data[MODE_W-1:0];
                CFG_PIX_THR:   r_pix_thr    <= i_cfg_data[PIX_W-1:0];
                CFG_MASK_CNT:  r_mask_cnt   <= i_cfg_data[CNT_W-1:0];
                CFG_REG_THR_0: r_reg_thr[0] <= i_cfg_data[PIX_W-1:0];
                CFG_REG_THR_1: r_reg_thr[1] <= i_cfg_data[PIX_W-1:0];
                CFG_REG_THR_2: r_reg_thr[2] <= i_cfg_data[PIX_W-1:0];
                CFG_REG_THR_3: r_reg_thr[3] <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        diff = (i_pix.old_pixel > i_pix.new_pixel) ? i_pix.old_pixel - i_pix.new_pixel
                                                   : i_pix.new_pixel - i_pix.old_pixel;
        pass = (diff >= r_pix_thr);

        o_entry.use_mask     = (r_mode == MODE_MASK);
        o_entry.regions_mode = (r_mode == MODE_REGIONS);
        o_entry.last         = i_pix.last;
        // mode three falls back to the all-pixels rule
        if (r_mode == MODE_MASK) begin
            o_entry.inc_changed = pass & i_pix.region_mask[0];
        end else begin
            o_entry.inc_changed = pass & (r_mode != MODE_REGIONS);
        end
        for (int r = 0; r < HW_REGIONS; r++) begin
            o_entry.inc_region[r] = (r < NUM_REGIONS) && (r_mode == MODE_REGIONS) && pass
                                    && i_pix.region_mask[r] && (diff >= r_reg_thr[r]);
        end
    end

    assign o_stall      = i_full;
    assign o_push       = i_valid & ~i_full;
    assign o_mask_count = r_mask_cnt;

endmodule

`default_nettype wire

FILE: hw/rtl/gfdc_fifo.sv
// ----------------------------------------------------------------------------
// gfdc_fifo
// Short queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gfdc_fifo
    import gfdc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_entry,
    input  wire logic i_pop,
    output t_cls      o_head,
    output logic      o_empty,
    output logic      o_full
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_FW = $clog2(FIFO_DEPTH + 1);

    t_cls               r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_FW-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_FW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_FW'(1);
            end
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FW'(FIFO_DEPTH));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("transfer into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: hw/rtl/gfdc_back.sv
// ----------------------------------------------------------------------------
// gfdc_back
// Frame counters, end-of-frame percent divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gfdc_back
    import gfdc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cls             i_head,
    input  wire logic             i_empty,
    output logic                  o_pop,
    input  wire logic [CNT_W-1:0] i_mask_count,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output t_res                  o_res
);

    localparam int STEP_W = $clog2(DIV_W);

    typedef enum logic [1:0] {
        S_RUN,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_pix_cnt;
    logic [CNT_W-1:0]   r_chg_cnt;
    logic [CNT_W-1:0]   r_reg_cnt [HW_REGIONS];
    logic [CNT_W-1:0]   r_num;
    logic [CNT_W-1:0]   r_den;
    logic [DIV_W-1:0]   r_quo;
    logic [CNT_W-1:0]   r_rem;
    logic [STEP_W-1:0]  r_step;
    logic               r_out_valid;
    t_res               r_out;

    logic [CNT_W-1:0]   n_pix_cnt;
    logic [CNT_W-1:0]   n_chg_cnt;
    logic [CNT_W-1:0]   n_reg_cnt [HW_REGIONS];
    logic [CNT_W:0]     trial;
    logic               trial_ge;
    logic [CNT_W-1:0]   n_rem;
    logic [PCT_W-1:0]   pct;
    logic               out_xfer;

    assign out_xfer = r_out_valid & ~i_stall;

    // a last pixel waits until the result register is free
    assign o_pop = !i_empty && (r_state == S_RUN)
                   && (!i_head.last || !r_out_valid || !i_stall);

    always_comb begin
        n_pix_cnt = bump(r_pix_cnt);
        n_chg_cnt = i_head.inc_changed ? bump(r_chg_cnt) : r_chg_cnt;
        for (int r = 0; r < HW_REGIONS; r++) begin
            n_reg_cnt[r] = i_head.inc_region[r] ? bump(r_reg_cnt[r]) : r_reg_cnt[r];
        end

        // one restoring divide step per cycle
        trial    = {r_rem, r_quo[DIV_W-1]};
        trial_ge = (trial >= {1'b0, r_den});
        n_rem    = trial_ge ? CNT_W'(trial - {1'b0, r_den}) : trial[CNT_W-1:0];

        if (r_den == '0) begin
            pct = '0;
        end else if (r_quo > DIV_W'(PCT_FULL)) begin
            pct = PCT_FULL;
        end else begin
            pct = r_quo[PCT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_pix_cnt   <= '0;
            r_chg_cnt   <= '0;
            for (int r = 0; r < HW_REGIONS; r++) begin
                r_reg_cnt[r] <= '0;
            end
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_RUN: begin
                    if (o_pop) begin
                        if (i_head.last) begin
                            r_pix_cnt <= '0;
                            r_chg_cnt <= '0;
                            for (int r = 0; r < HW_REGIONS; r++) begin
                                r_reg_cnt[r] <= '0;
                            end
                            if (i_head.regions_mode) begin
                                r_out_valid          <= 1'b1;
                                r_out.percent        <= '0;
                                r_out.region_count_0 <= n_reg_cnt[0];
                                r_out.region_count_1 <= n_reg_cnt[1];
                                r_out.region_count_2 <= n_reg_cnt[2];
                                r_out.region_count_3 <= n_reg_cnt[3];
                            end else begin
                                r_num   <= n_chg_cnt;
                                r_den   <= i_head.use_mask ? i_mask_count : n_pix_cnt;
                                r_state <= S_MUL;
                            end
                        end else begin
                            r_pix_cnt <= n_pix_cnt;
                            r_chg_cnt <= n_chg_cnt;
                            for (int r = 0; r < HW_REGIONS; r++) begin
                                r_reg_cnt[r] <= n_reg_cnt[r];
                            end
                        end
                    end
                end
                S_MUL: begin
                    r_quo   <= DIV_W'(r_num) * DIV_W'(PCT_FULL);
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[DIV_W-2:0], trial_ge};
                    if (r_step == STEP_W'(DIV_W - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_DONE: begin
                    r_out_valid          <= 1'b1;
                    r_out.percent        <= pct;
                    r_out.region_count_0 <= '0;
                    r_out.region_count_1 <= '0;
                    r_out.region_count_2 <= '0;
                    r_out.region_count_3 <= '0;
                    r_state              <= S_RUN;
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    a_div_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> !r_out_valid)
        else $error("result register busy while percent is computed");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.percent <= PCT_FULL))
        else $error("percent above full scale");

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pix_cnt <= CNT_LIMIT) && (r_chg_cnt <= CNT_LIMIT))
        else $error("frame counter beyond saturation limit");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_DIV) && !o_pop)
        else $error("queue popped during divide");

endmodule

`default_nettype wire

FILE: hw/rtl/gray_frame_diff_counter.sv
// ----------------------------------------------------------------------------
// gray_frame_diff_counter
// Frame-difference motion counter for 8-bit gray pixel pairs.
// ----------------------------------------------------------------------------
// Pixels are taken at one per clock while not stalled. Each pixel is
// classified on entry and queued (four entries) to the counting side, which
// also consumes one per clock while counting. The frame result is issued
// after the pixel marked last: in regions mode in the cycle after that pixel
// leaves the queue; in the percent modes the percent comes from a multiply
// state, a bit-serial divider and a finish state, during which the queue
// absorbs the next frame's first pixels and then stalls the input. A last
// pixel is held in the queue while an earlier result is not yet transferred.
`default_nettype none

module gray_frame_diff_counter
    import gfdc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_pix                  i_pix,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_res                       o_res
);

    logic             push;
    logic             pop;
    logic             empty;
    logic             full;
    t_cls             entry;
    t_cls             head;
    logic [CNT_W-1:0] mask_count;

    gfdc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pix        (i_pix),
        .i_full       (full),
        .o_push       (push),
        .o_entry      (entry),
        .o_mask_count (mask_count)
    );

    gfdc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    gfdc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (empty),
        .o_pop        (pop),
        .i_mask_count (mask_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

FILE: sim/tb_gray_frame_diff_counter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gray_frame_diff_counter
// Self-checking bench for the gray frame difference counter.
// ----------------------------------------------------------------------------
// Pixel pairs are pushed through the valid/stall input and frame results
// are pulled from the output with random gaps and stalls on both sides. A
// scoreboard tracks the register file and the frame counters, predicts each
// frame result when a last pixel is transferred, and compares each result
// field by field. A directed frame set covers every mode, the threshold
// extremes, zero divisor, percent saturation, the unused mode code, an
// ignored register index and a mode switch inside a frame. Randomized frames
// with random register settings follow.
// ----------------------------------------------------------------------------

module tb_gray_frame_diff_counter;
    import gfdc_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd7;
    localparam int unsigned          PERCENT_FULL = 100;
    localparam int unsigned          CNT_SAT      =
        (MAX_PIXELS < (1 << CNT_W) - 1) ? MAX_PIXELS : (1 << CNT_W) - 1;
    localparam int SETTLE_CYCLES  = 48;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PIXELS  = 700;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    t_pix                  i_pix;
    logic                  o_valid;
    logic                  i_stall;
    t_res                  o_res;

    // frame counter model and queue of predicted frame results
    class frame_scoreboard;
        logic [MODE_W-1:0] mode;
        logic [7:0]        pix_thr;
        logic [CNT_W-1:0]  mask_cnt;
        logic [7:0]        reg_thr[HW_REGIONS];
        int unsigned       pix_cnt;
        int unsigned       chg_cnt;
        int unsigned       reg_cnt[HW_REGIONS];
        t_res              expected_frames[$];
        int                errors;
        int                frames_checked;

        function new();
            mode     = MODE_ALL;
            pix_thr  = '0;
            mask_cnt = '0;
            foreach (reg_thr[i]) reg_thr[i] = '0;
            clear_counts();
            errors         = 0;
            frames_checked = 0;
        endfunction

        function void clear_counts();
            pix_cnt = 0;
            chg_cnt = 0;
            foreach (reg_cnt[i]) reg_cnt[i] = 0;
        endfunction

        function int unsigned sat_inc(int unsigned c);
            return (c < CNT_SAT) ? c + 1 : c;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MODE:      mode       = data[MODE_W-1:0];
                CFG_PIX_THR:   pix_thr    = data[7:0];
                CFG_MASK_CNT:  mask_cnt   = data[CNT_W-1:0];
                CFG_REG_THR_0: reg_thr[0] = data[7:0];
                CFG_REG_THR_1: reg_thr[1] = data[7:0];
                CFG_REG_THR_2: reg_thr[2] = data[7:0];
                CFG_REG_THR_3: reg_thr[3] = data[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function void note_pixel(t_pix p);
            logic [7:0]      diff;
            logic            changed;
            t_res            res;
            longint unsigned den;
            longint unsigned q;
            diff = (p.old_pixel > p.new_pixel) ? p.old_pixel - p.new_pixel
                                               : p.new_pixel - p.old_pixel;
            changed = (diff >= pix_thr);
            pix_cnt = sat_inc(pix_cnt);
            if (mode == MODE_REGIONS) begin
                if (changed) begin
                    for (int i = 0; i < HW_REGIONS && i < NUM_REGIONS; i++) begin
                        if (p.region_mask[i] && diff >= reg_thr[i])
                            reg_cnt[i] = sat_inc(reg_cnt[i]);
                    end
                end
            end else if (mode == MODE_MASK) begin
                if (p.region_mask[0] && changed)
                    chg_cnt = sat_inc(chg_cnt);
            end else if (changed) begin
                chg_cnt = sat_inc(chg_cnt);
            end
            if (!p.last)
                return;
            res = '0;
            if (mode == MODE_REGIONS) begin
                res.region_count_0 = CNT_W'(reg_cnt[0]);
                res.region_count_1 = CNT_W'(reg_cnt[1]);
                res.region_count_2 = CNT_W'(reg_cnt[2]);
                res.region_count_3 = CNT_W'(reg_cnt[3]);
            end else begin
                den = (mode == MODE_MASK) ? 64'(mask_cnt) : 64'(pix_cnt);
                q   = 0;
                if (den != 0)
                    q = (64'(chg_cnt) * PERCENT_FULL) / den;
                res.percent = (q > PERCENT_FULL) ? PCT_W'(PERCENT_FULL) : PCT_W'(q);
            end
            expected_frames.push_back(res);
            clear_counts();
        endfunction

        function void compare(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_frames.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: percent %0d counts %0d %0d %0d %0d",
                         $time, got.percent, got.region_count_0, got.region_count_1,
                         got.region_count_2, got.region_count_3);
                return;
            end
            want = expected_frames.pop_front();
            frames_checked++;
            compare("percent", CNT_W'(want.percent), CNT_W'(got.percent));
            compare("region_count_0", want.region_count_0, got.region_count_0);
            compare("region_count_1", want.region_count_1, got.region_count_1);
            compare("region_count_2", want.region_count_2, got.region_count_2);
            compare("region_count_3", want.region_count_3, got.region_count_3);
        endfunction
    endclass

    frame_scoreboard sb = new();

    int  sent_pixels = 0;
    int  settings    = 0;
    bit  gaps_on     = 1'b1;
    bit  stall_on    = 1'b1;

    gray_frame_diff_counter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pix      (i_pix),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // transfers are sampled on the edge, before any testbench update lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.apply_reg(i_cfg_idx, i_cfg_data);
            if (i_valid && !o_stall)
                sb.note_pixel(i_pix);
            if (o_valid && !i_stall)
                sb.check_result(o_res);
        end
    end

    // output back-pressure: alternating stall / no-stall spans
    initial begin
        int span;
        bit hold;
        span    = 0;
        hold    = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                if (!stall_on) begin
                    hold = 1'b0;
                    span = 1;
                end else if (hold) begin
                    hold = 1'b0;
                    span = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                                                        : $urandom_range(30, 120);
                end else begin
                    hold = 1'b1;
                    span = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                        : $urandom_range(20, 60);
                end
            end
            i_stall <= hold;
            span--;
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet);
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_pix pix(int a, int b, int m, bit l);
        t_pix p;
        p.old_pixel   = PIX_W'(a);
        p.new_pixel   = PIX_W'(b);
        p.region_mask = MASK_W'(m);
        p.last        = l;
        return p;
    endfunction

    // valid stays high across back-to-back transfers
    task automatic send_pixel(input t_pix p);
        int gap;
        gap = pick_gap();
        i_valid <= 1'b1;
        i_pix   <= p;
        do @(posedge i_clk); while (o_stall);
        sent_pixels++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait for all frame results; optionally let the divider and queue settle
    task automatic drain(input bit settle);
        i_valid <= 1'b0;
        // one edge so the last transfer is already on the scoreboard
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write enable is lowered by cfg_done, so consecutive writes keep it high
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
    endtask

    task automatic cfg_done();
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [7:0] pick_thr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'd0;
        if (r < 30)
            return 8'd255;
        if (r < 65)
            return 8'($urandom_range(1, 40));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_setting(input int frame_len);
        logic [CFG_DATA_W-1:0] d;
        int r;
        d = CFG_DATA_W'($urandom());
        r = $urandom_range(0, 9);
        d[MODE_W-1:0] = (r < 3) ? MODE_ALL : (r < 6) ? MODE_MASK
                      : (r < 9) ? MODE_REGIONS : MODE_SPARE;
        cfg_write(CFG_MODE, d);
        if ($urandom_range(0, 9) < 7) begin
            d = CFG_DATA_W'($urandom());
            d[7:0] = pick_thr();
            cfg_write(CFG_PIX_THR, d);
        end
        if ($urandom_range(0, 1) == 1) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                d = '0;
            else if (r < 70)
                d = CFG_DATA_W'($urandom_range(1, frame_len + 8));
            else if (r < 80)
                d = CFG_DATA_W'(MAX_PIXELS);
            else if (r < 85)
                d = '1;
            else
                d = CFG_DATA_W'($urandom());
            cfg_write(CFG_MASK_CNT, d);
        end
        for (int i = 0; i < HW_REGIONS; i++) begin
            if ($urandom_range(0, 1) == 1) begin
                d = CFG_DATA_W'($urandom());
                d[7:0] = pick_thr();
                cfg_write(CFG_IDX_W'(CFG_REG_THR_0 + i), d);
            end
        end
        if ($urandom_range(0, 9) == 0)
            cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom()));
        cfg_done();
    endtask

    // pixel pairs biased toward differences at or next to a live threshold
    function automatic t_pix rand_pixel(bit l);
        t_pix p;
        int   d;
        int   a;
        int   t;
        case ($urandom_range(0, 5))
            0, 1: begin
                a = $urandom_range(0, 255);
                p = pix(a, $urandom_range(0, 255), 0, l);
            end
            2, 3: begin
                t = ($urandom_range(0, 1) == 1) ? sb.pix_thr
                                                : sb.reg_thr[$urandom_range(0, 3)];
                d = t + $urandom_range(0, 2) - 1;
                d = (d < 0) ? 0 : (d > 255) ? 255 : d;
                a = $urandom_range(0, 255 - d);
                p = ($urandom_range(0, 1) == 1) ? pix(a, a + d, 0, l) : pix(a + d, a, 0, l);
            end
            4: begin
                a = $urandom_range(0, 1) * 255;
                p = pix(a, $urandom_range(0, 1) * 255, 0, l);
            end
            default: begin
                a = $urandom_range(0, 255);
                p = pix(a, a, 0, l);
            end
        endcase
        p.region_mask = MASK_W'($urandom_range(0, 15));
        return p;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, 40);
        return $urandom_range(100, 250);
    endfunction

    initial begin
        int random_start;
        int frames;
        int len;
        bit close;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_pix      = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // upper data bits set to show the registers keep only their width
        cfg_write(CFG_MODE, {21'h1FFFFF, MODE_ALL});
        cfg_write(CFG_PIX_THR, {15'h7FFF, 8'd0});
        cfg_write(CFG_MASK_CNT, '0);
        cfg_write(CFG_REG_THR_0, {15'h7FFF, 8'd0});
        cfg_write(CFG_REG_THR_1, {15'h2A5A, 8'd255});
        cfg_write(CFG_REG_THR_2, {15'h0000, 8'd100});
        cfg_write(CFG_REG_THR_3, {15'h1234, 8'd50});
        cfg_done();

        // all pixels, zero threshold: every pixel counts
        send_pixel(pix(0, 255, 0, 0));
        send_pixel(pix(255, 0, 15, 0));
        send_pixel(pix(128, 128, 5, 1));
        drain(1);
        cfg_write(CFG_PIX_THR, 23'd255);
        cfg_done();
        send_pixel(pix(0, 255, 1, 0));
        send_pixel(pix(255, 0, 2, 0));
        send_pixel(pix(10, 20, 4, 0));
        send_pixel(pix(0, 0, 8, 1));
        send_pixel(pix(7, 7, 15, 1));

        // masked mode: zero divisor, then saturation above 100, then huge divisor
        drain(1);
        cfg_write(CFG_MODE, {21'h0AAAAA, MODE_MASK});
        cfg_write(CFG_MASK_CNT, '0);
        cfg_done();
        send_pixel(pix(0, 255, 1, 0));
        send_pixel(pix(255, 0, 1, 1));
        drain(1);
        cfg_write(CFG_MASK_CNT, 23'd1);
        cfg_write(CFG_PIX_THR, 23'd0);
        cfg_done();
        send_pixel(pix(1, 2, 1, 0));
        send_pixel(pix(3, 3, 15, 0));
        send_pixel(pix(9, 0, 14, 1));
        drain(1);
        cfg_write(CFG_MASK_CNT, CFG_DATA_W'(MAX_PIXELS));
        cfg_done();
        send_pixel(pix(255, 0, 1, 1));

        // unused mode code falls back to all pixels
        drain(1);
        cfg_write(CFG_MODE, {21'h155555, MODE_SPARE});
        cfg_write(CFG_PIX_THR, 23'd128);
        cfg_done();
        send_pixel(pix(0, 128, 0, 0));
        send_pixel(pix(0, 127, 0, 1));

        // regions: global gate at 60, per-region thresholds 0/255/100/50
        drain(1);
        cfg_write(CFG_MODE, CFG_DATA_W'(MODE_REGIONS));
        cfg_write(CFG_PIX_THR, 23'd60);
        cfg_write(CFG_UNUSED, '1);
        cfg_done();
        send_pixel(pix(0, 255, 15, 0));
        send_pixel(pix(100, 0, 15, 0));
        send_pixel(pix(0, 70, 15, 0));
        send_pixel(pix(0, 59, 15, 0));
        send_pixel(pix(255, 200, 6, 1));

        // mode switch inside a frame: regions pixels, then masked pixels
        send_pixel(pix(0, 200, 15, 0));
        send_pixel(pix(50, 50, 3, 0));
        drain(1);
        cfg_write(CFG_MODE, CFG_DATA_W'(MODE_MASK));
        cfg_write(CFG_MASK_CNT, 23'd2);
        cfg_done();
        send_pixel(pix(0, 255, 1, 0));
        send_pixel(pix(0, 255, 1, 1));

        random_start = sent_pixels;
        while (sent_pixels - random_start < RANDOM_PIXELS) begin
            drain(1);
            len = pick_len();
            random_setting(len);
            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            frames   = $urandom_range(1, 4);
            for (int f = 0; f < frames; f++) begin
                // an open frame at a phase end carries into the next setting
                close = (f < frames - 1) || ($urandom_range(0, 4) != 0);
                for (int k = 0; k < len; k++)
                    send_pixel(rand_pixel(close && k == len - 1));
                if ($urandom_range(0, 7) == 0)
                    drain(0);
                len = pick_len();
            end
        end

        drain(1);
        $display("Covered %0d pixels under %0d register settings; %0d frame results checked.",
                 sent_pixels, settings, sb.frames_checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
